// ----- src/bvc_pkg.sv -----
// ----------------------------------------------------------------------------
// bvc_pkg
// Shared types and constants of the buffer view cache: the request and
// result words, the stored view entry and the configuration register map.
// ----------------------------------------------------------------------------
package bvc_pkg;

  // field widths
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned START_W  = 33;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned EBYTES_W = 13;
  localparam int unsigned ETOTAL_W = 21;
  localparam int unsigned TOTAL_W  = EBYTES_W + ETOTAL_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_START  = 2'd0,
    REG_ELEMENT_BYTES = 2'd1,
    REG_ELEMENT_TOTAL = 2'd2
  } cfg_reg_t;

  // request word
  typedef struct packed {
    logic [OFFSET_W-1:0] req_offset;
    logic [SIZE_W-1:0]   req_size;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               reused;
    logic [START_W-1:0] first_element;
    logic [SIZE_W-1:0]  element_count;
  } out_word_t;

  // one cached view
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  length;
  } entry_t;

endpackage

// ----- src/bvc_entry_mem.sv -----
// ----------------------------------------------------------------------------
// bvc_entry_mem
// Single-port-write, single-port-read view store with registered read data.
// ----------------------------------------------------------------------------
module bvc_entry_mem
  import bvc_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/bvc_div.sv -----
// ----------------------------------------------------------------------------
// bvc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvc_div
  import bvc_pkg::*;
#(
  parameter int unsigned DW = 33,
  parameter int unsigned VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    q_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dv_r;

  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, q_r[DW-1]};
    diff    = rem_sh - {1'b0, dv_r};
    ge      = (rem_sh >= {1'b0, dv_r});
    rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ----- src/buffer_view_cache.sv -----
// ----------------------------------------------------------------------------
// buffer_view_cache
// Fully associative cache of buffer views with in-order fill and
// round-robin replacement once full.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (byte offset, byte size; size zero means up to the buffer
//   end) is taken when start is high and busy is low. Exactly one result word
//   follows, shown for a single cycle with out_valid high; it gives the slot,
//   a reused flag and the view's first element and element count.
//   Sequence: the size is formed first, then the entry memory is searched one
//   entry per cycle (up to the hit, or every filled entry on a miss, then
//   the new view is written), then two serial dividers run side by side,
//   the longer of them in 33 steps.
//   One request is in flight at a time; busy stays high until its result.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the
//   user must write it only while busy is low; the block does not enforce it.
//   Reset empties the cache by clearing the fill count and replacement
//   cursor; the entry memory itself needs no clearing pass.
//   The result cannot be held off: it is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module buffer_view_cache
  import bvc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  // result channel
  output logic                  out_valid,
  output out_word_t             out_word,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int unsigned FILL_W = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_MISS,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [OFFSET_W-1:0] buf_start_r;
  logic [EBYTES_W-1:0] ebytes_r;
  logic [ETOTAL_W-1:0] etotal_r;

  // request context
  logic [OFFSET_W-1:0] off_r;
  logic [SIZE_W-1:0]   size_r;
  logic [START_W-1:0]  abs_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [SIZE_W-1:0]   len_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [IDX_W-1:0]    slot_r;
  logic                reused_r;

  // cache bookkeeping
  logic [FILL_W-1:0] fill_r;
  logic [IDX_W-1:0]  cursor_r;

  // result registers
  logic      out_valid_r;
  out_word_t out_word_r;

  // memory ports
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;

  // dividers
  logic                div_go;
  logic [EBYTES_W-1:0] divisor;
  logic                div_s_busy;
  logic                div_l_busy;
  logic [START_W-1:0]  q_start;
  logic [SIZE_W-1:0]   q_length;

  // combinational decisions
  logic               accept;
  logic [TOTAL_W-1:0] total_c;
  logic [TOTAL_W-1:0] to_end;
  logic [SIZE_W-1:0]  size_fin;
  logic               scan_hit;
  logic               scan_last;
  logic [IDX_W-1:0]   victim;
  logic [IDX_W-1:0]   cursor_nxt;
  logic [IDX_W+3:0]   slot_ext;

  assign accept  = start && (state_r == ST_IDLE);
  assign total_c = {{EBYTES_W{1'b0}}, etotal_r} * {{ETOTAL_W{1'b0}}, ebytes_r};
  assign divisor = (ebytes_r == '0) ? EBYTES_W'(1) : ebytes_r;

  // final size: the request size, or if zero the size up to buffer end, saturated to 32 bits
  always_comb begin
    to_end = total_r - {{(TOTAL_W-OFFSET_W){1'b0}}, off_r};
    if (size_r != '0) begin
      size_fin = size_r;
    end else if (total_r <= {{(TOTAL_W-OFFSET_W){1'b0}}, off_r}) begin
      size_fin = '0;
    end else if (to_end[TOTAL_W-1:SIZE_W] != '0) begin
      size_fin = '1;
    end else begin
      size_fin = to_end[SIZE_W-1:0];
    end
  end

  // search compare on the entry just read
  assign scan_hit  = (state_r == ST_SCAN) && (mem_rd_data.start == abs_r) &&
                     (size_r <= mem_rd_data.length);
  assign scan_last = ((FILL_W'(scan_idx_r) + FILL_W'(1)) == fill_r);

  // replacement choice: first empty entry, else round-robin cursor
  assign victim     = (fill_r < FILL_W'(CACHE_ENTRIES)) ? fill_r[IDX_W-1:0] : cursor_r;
  assign cursor_nxt = (victim == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : victim + 1'b1;

  // memory access control
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = victim;
    mem_wr_data = '{start: abs_r, length: size_r};
    case (state_r)
      ST_PREP: begin
        mem_rd_en = 1'b1;
      end
      ST_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = scan_idx_r + 1'b1;
      end
      ST_MISS: begin
        mem_wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign div_go = (state_r == ST_DIV_GO);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_start_r <= '0;
      ebytes_r    <= EBYTES_W'(4);
      etotal_r    <= ETOTAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_START:  buf_start_r <= cfg_data[OFFSET_W-1:0];
        REG_ELEMENT_BYTES: ebytes_r    <= cfg_data[EBYTES_W-1:0];
        REG_ELEMENT_TOTAL: etotal_r    <= cfg_data[ETOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= (fill_r == '0) ? ST_MISS : ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            state_r <= ST_DIV_GO;
          end else if (scan_last) begin
            state_r <= ST_MISS;
          end
        end
        ST_MISS: begin
          cursor_r <= cursor_nxt;
          if (fill_r < FILL_W'(CACHE_ENTRIES)) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (!div_s_busy && !div_l_busy) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      off_r   <= in_word.req_offset;
      size_r  <= in_word.req_size;
      abs_r   <= {1'b0, buf_start_r} + {1'b0, in_word.req_offset};
      total_r <= total_c;
    end
    case (state_r)
      ST_PREP: begin
        size_r     <= size_fin;
        scan_idx_r <= '0;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          slot_r   <= scan_idx_r;
          reused_r <= 1'b1;
          len_r    <= mem_rd_data.length;
        end else begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end
      ST_MISS: begin
        slot_r   <= victim;
        reused_r <= 1'b0;
        len_r    <= size_r;
      end
      default: begin
      end
    endcase
  end

  // result word
  assign slot_ext = {4'b0000, slot_r};

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_WAIT && !div_s_busy && !div_l_busy) begin
      out_word_r.slot          <= slot_ext[SLOT_W-1:0];
      out_word_r.reused        <= reused_r;
      out_word_r.first_element <= q_start;
      out_word_r.element_count <= q_length;
    end
  end

  bvc_entry_mem #(
    .DEPTH (CACHE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bvc_div #(
    .DW (START_W),
    .VW (EBYTES_W)
  ) u_div_start (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (abs_r),
    .divisor  (divisor),
    .busy     (div_s_busy),
    .quotient (q_start)
  );

  bvc_div #(
    .DW (SIZE_W),
    .VW (EBYTES_W)
  ) u_div_length (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (len_r),
    .divisor  (divisor),
    .busy     (div_l_busy),
    .quotient (q_length)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // result strobe lasts a single cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // result is only shown once the sequencer is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while a request is still active");

  // fill count never passes the cache depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CACHE_ENTRIES))
    else $error("fill count beyond cache depth");

  // a reused view always lies inside the filled region
  a_hit_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && reused_r) |-> (FILL_W'(slot_r) < fill_r))
    else $error("hit reported on an empty entry");

  // dividers are idle whenever a new request may enter
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!div_s_busy && !div_l_busy))
    else $error("request accepted while a division is running");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for buffer_view_cache. Bind requests go in through the
// start/busy handshake, and a model of the view cache works out
// the word that each one should return. Returned words are checked in order
// against the model. Directed cases cover hits, misses, size to the buffer
// end, wide and zero settings and round-robin replacement. Random traffic
// then runs under three sender idle profiles, with settings changed between
// bursts.
// ----------------------------------------------------------------------------
module testbench;
  import bvc_pkg::*;

  localparam int unsigned VIEW_SLOTS   = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned BURST_LEN    = 150;
  localparam int unsigned PRINT_CAP    = 60;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model copy of the settings and the view cache
  logic [OFFSET_W-1:0] buf_start_q = '0;
  logic [EBYTES_W-1:0] elem_bytes_q = 13'd4;
  logic [ETOTAL_W-1:0] elem_total_q = 21'd1;
  logic                view_valid  [VIEW_SLOTS] = '{default: 1'b0};
  logic [START_W-1:0]  view_start  [VIEW_SLOTS] = '{default: '0};
  logic [SIZE_W-1:0]   view_length [VIEW_SLOTS] = '{default: '0};
  int unsigned         next_victim = 0;

  out_word_t   pending_views[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  buffer_view_cache #(
    .CACHE_ENTRIES(VIEW_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // look up or create the view for one bind request, updating the model
  function automatic out_word_t bind_view(input in_word_t req);
    logic [START_W-1:0]  abs_start;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [TOTAL_W-1:0]  span;
    logic [SIZE_W-1:0]   want;
    logic [EBYTES_W-1:0] divisor;
    logic                hit;
    int                  pick;
    int                  i;
    out_word_t           res;
    abs_start = {1'b0, buf_start_q} + {1'b0, req.req_offset};
    want = req.req_size;
    // size zero runs to the buffer end, saturating at 32 bits
    if (req.req_size == '0) begin
      total_bytes = {{EBYTES_W{1'b0}}, elem_total_q} * {{ETOTAL_W{1'b0}}, elem_bytes_q};
      span = (total_bytes > {2'b00, req.req_offset}) ?
             total_bytes - {2'b00, req.req_offset} : '0;
      want = (span > {2'b00, 32'hFFFF_FFFF}) ? 32'hFFFF_FFFF : span[SIZE_W-1:0];
    end
    divisor = (elem_bytes_q == '0) ? 13'd1 : elem_bytes_q;
    hit = 1'b0;
    pick = -1;
    // first valid match wins; first empty entry takes a new view
    for (i = 0; i < VIEW_SLOTS && pick < 0; i++) begin
      if (view_valid[i]) begin
        if (view_start[i] == abs_start && want <= view_length[i]) begin
          pick = i;
          hit = 1'b1;
        end
      end else begin
        pick = i;
      end
    end
    if (pick < 0)
      pick = next_victim;
    if (!hit) begin
      view_valid[pick]  = 1'b1;
      view_start[pick]  = abs_start;
      view_length[pick] = want;
      next_victim = (pick + 1) % VIEW_SLOTS;
    end
    res.slot          = pick[SLOT_W-1:0];
    res.reused        = hit;
    res.first_element = view_start[pick] / divisor;
    res.element_count = view_length[pick] / divisor;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result word %h with none expected", out_word));
      end else begin
        want = pending_views.pop_front();
        if (out_word.slot !== want.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", out_word.slot, want.slot));
        if (out_word.reused !== want.reused)
          report_mismatch($sformatf("reused %b, expected %b",
                                    out_word.reused, want.reused));
        if (out_word.first_element !== want.first_element)
          report_mismatch($sformatf("first_element %h, expected %h",
                                    out_word.first_element, want.first_element));
        if (out_word.element_count !== want.element_count)
          report_mismatch($sformatf("element_count %h, expected %h",
                                    out_word.element_count, want.element_count));
      end
    end
  end

  // send one request word and queue its expected result
  task automatic bind_request(input logic [OFFSET_W-1:0] offset,
                              input logic [SIZE_W-1:0] size);
    in_word_t  req;
    out_word_t exp_word;
    req.req_offset = offset;
    req.req_size   = size;
    @(negedge clk);
    start   <= 1'b1;
    in_word <= req;
    do @(posedge clk); while (busy !== 1'b0);
    exp_word = bind_view(req);
    pending_views = {pending_views, exp_word};
  endtask

  task automatic sender_pause(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // hold off until every expected word is back and the block is idle
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_BUFFER_START:  buf_start_q  = data;
      REG_ELEMENT_BYTES: elem_bytes_q = data[EBYTES_W-1:0];
      REG_ELEMENT_TOTAL: elem_total_q = data[ETOTAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reuse on equal start and sufficient length, creation otherwise
  task automatic test_reuse_and_create();
    bind_request(32'd0, 32'd0);
    bind_request(32'd0, 32'd4);
    bind_request(32'd0, 32'd2);
    bind_request(32'd0, 32'd8);
    bind_request(32'd0, 32'd6);
  endtask

  // size zero: inside the buffer, at its end and beyond it
  task automatic test_size_to_end();
    bind_request(32'd2, 32'd0);
    bind_request(32'd4, 32'd0);
    bind_request(32'd100, 32'd0);
  endtask

  // widest start carry, zero element size and saturated sizes
  task automatic test_extremes();
    wait_idle();
    write_reg(REG_BUFFER_START, 32'hFFFF_FFFF);
    write_reg(REG_ELEMENT_BYTES, 32'd0);
    write_reg(REG_ELEMENT_TOTAL, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h1234_5678);
    bind_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    bind_request(32'd0, 32'd0);
    wait_idle();
    write_reg(REG_ELEMENT_BYTES, 32'hFFFF_FFFF);
    bind_request(32'd0, 32'd0);
    bind_request(32'hFFFF_FFFF, 32'd0);
    wait_idle();
    write_reg(REG_ELEMENT_BYTES, 32'd4096);
    write_reg(REG_ELEMENT_TOTAL, 32'd1048576);
    write_reg(REG_BUFFER_START, 32'd0);
    bind_request(32'd0, 32'd0);
  endtask

  // fill every entry, then wrap the round-robin cursor
  task automatic test_replacement();
    int unsigned k;
    int          i;
    logic        full;
    wait_idle();
    write_reg(REG_BUFFER_START, 32'h0000_1000);
    write_reg(REG_ELEMENT_BYTES, 32'd16);
    write_reg(REG_ELEMENT_TOTAL, 32'd256);
    k = 0;
    full = 1'b0;
    while (!full) begin
      bind_request(32'h0001_0000 + 16 * k, 32'd16);
      k++;
      full = 1'b1;
      for (i = 0; i < VIEW_SLOTS; i++)
        full &= view_valid[i];
    end
    repeat (4) begin
      bind_request(32'h0001_0000 + 16 * k, 32'd32);
      k++;
    end
    bind_request(32'h0001_0000 + 16 * (k - 1), 32'd8);
  endtask

  // new settings between bursts, extremes among them
  task automatic shuffle_settings();
    wait_idle();
    case ($urandom_range(5))
      0:       write_reg(REG_BUFFER_START, 32'd0);
      1:       write_reg(REG_BUFFER_START, 32'hFFFF_FFFF);
      default: write_reg(REG_BUFFER_START, $urandom);
    endcase
    case ($urandom_range(6))
      0:       write_reg(REG_ELEMENT_BYTES, 32'd0);
      1:       write_reg(REG_ELEMENT_BYTES, 32'd1);
      2:       write_reg(REG_ELEMENT_BYTES, 32'hFFFF_FFFF);
      3:       write_reg(REG_ELEMENT_BYTES, 32'd4096);
      default: write_reg(REG_ELEMENT_BYTES, $urandom_range(1, 64));
    endcase
    case ($urandom_range(6))
      0:       write_reg(REG_ELEMENT_TOTAL, 32'd0);
      1:       write_reg(REG_ELEMENT_TOTAL, 32'd1);
      2:       write_reg(REG_ELEMENT_TOTAL, 32'hFFFF_FFFF);
      3:       write_reg(REG_ELEMENT_TOTAL, 32'd1048576);
      default: write_reg(REG_ELEMENT_TOTAL, $urandom_range(1, 4096));
    endcase
    if ($urandom_range(3) == 0)
      write_reg(REG_SPARE, $urandom);
  endtask

  // random bind traffic, much of it aimed at views already held
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned count);
    int unsigned         n;
    int unsigned         s;
    logic [START_W-1:0]  rel;
    logic [OFFSET_W-1:0] offset;
    logic [SIZE_W-1:0]   size;
    for (n = 0; n < count; n++) begin
      if (n % BURST_LEN == 0)
        shuffle_settings();
      offset = $urandom;
      size   = $urandom;
      s = $urandom_range(99);
      if (s < 45) begin
        // revisit a held view, relative to the current buffer start
        s = $urandom_range(VIEW_SLOTS - 1);
        rel = view_start[s] - {1'b0, buf_start_q};
        if (view_valid[s] && !rel[START_W-1]) begin
          offset = rel[OFFSET_W-1:0];
          case ($urandom_range(3))
            0:       size = view_length[s];
            1:       size = $urandom_range(0, view_length[s]);
            2:       size = view_length[s] + 32'd1;
            default: size = '0;
          endcase
        end
      end else if (s < 80) begin
        // small pool of element-aligned offsets
        offset = elem_bytes_q * $urandom_range(7);
        size = ($urandom_range(2) == 0) ? '0 : elem_bytes_q * $urandom_range(1, 8);
      end else if (s < 90) begin
        size = '0;
      end
      sender_pause(idle_pct);
      bind_request(offset, size);
    end
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reuse_and_create();
    test_size_to_end();
    test_extremes();
    test_replacement();
    test_random_traffic(11, 450);
    test_random_traffic(78, 450);
    test_random_traffic(0, 450);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
